### rtl/gic_pkg.sv
// ---------------------------------------------------------------------------
// gic_pkg
// Shared types and constants for the gamepad input conditioner.
// ---------------------------------------------------------------------------
package gic_pkg;

  localparam int AXIS_W     = 12;
  localparam int NUM_AXES   = 4;
  localparam int NUM_BTNS   = 4;
  localparam int TIME_W     = 32;
  localparam int DELAY_W    = 16;
  localparam int WINDOW_DEF = 15;
  localparam int IN_W       = 88;
  localparam int OUT_W      = 88;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [AXIS_W-1:0]    DEADZONE_RST = AXIS_W'(500);
  localparam logic [DELAY_W-1:0]   DELAY_RST    = DELAY_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b1;

  // button lane order
  localparam int BTN_JOY1  = 0;
  localparam int BTN_JOY2  = 1;
  localparam int BTN_LTRIG = 2;
  localparam int BTN_RTRIG = 3;

  typedef enum logic [1:0] {
    BTN_RELEASED      = 2'd0,
    BTN_JUST_PRESSED  = 2'd1,
    BTN_PRESSED       = 2'd2,
    BTN_JUST_RELEASED = 2'd3
  } btn_state_t;

  // pipeline strobes shared by all lanes
  typedef struct packed {
    logic acc;     // input item accepted
    logic ld2;     // stage 2 load
    logic ld3;     // output stage load
    logic primed;  // histories already filled
  } pipe_ctl_t;

endpackage

### rtl/gic_axis_lane.sv
// ---------------------------------------------------------------------------
// gic_axis_lane
// One axis: shift-line history, running sum, reciprocal divide, deadzone pick.
// ---------------------------------------------------------------------------
module gic_axis_lane #(
  parameter int WINDOW = gic_pkg::WINDOW_DEF
) (
  input  logic                      clk,
  input  gic_pkg::pipe_ctl_t        ctl,
  input  logic [gic_pkg::AXIS_W-1:0] sample,
  input  logic [gic_pkg::AXIS_W-1:0] deadzone,
  output logic [gic_pkg::AXIS_W-1:0] filt
);
  import gic_pkg::*;

  localparam int SUM_W  = AXIS_W + $clog2(WINDOW);
  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int MUL_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic [AXIS_W-1:0] hist_r   [WINDOW];
  logic [AXIS_W-1:0] hist_nxt [WINDOW];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [AXIS_W-1:0] samp_r;
  logic [AXIS_W-1:0] avg, diff;

  always_comb begin
    hist_nxt[0] = sample;
    for (int i = 1; i < WINDOW; i++) begin
      hist_nxt[i] = ctl.primed ? hist_r[i-1] : sample;
    end
    if (ctl.primed) begin
      sum_nxt = sum_r + SUM_W'(sample) - SUM_W'(hist_r[WINDOW-1]);
    end else begin
      sum_nxt = SUM_W'(sample) * SUM_W'(WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      hist_r <= hist_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // sum / WINDOW as multiply by rounded-up reciprocal, exact over the sum range
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      prod_r <= PROD_W'(sum_r) * PROD_W'(RECIP[MUL_W-1:0]);
      samp_r <= hist_r[0];
    end
  end

  always_comb begin
    avg  = prod_r[SHIFT +: AXIS_W];
    diff = (samp_r >= avg) ? (samp_r - avg) : (avg - samp_r);
    filt = (diff < deadzone) ? avg : samp_r;
  end

endmodule

### rtl/gic_button_lane.sv
// ---------------------------------------------------------------------------
// gic_button_lane
// Four-state time-based debouncer for one button.
// ---------------------------------------------------------------------------
module gic_button_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gic_pkg::pipe_ctl_t          ctl,
  input  logic                        level,
  input  logic [gic_pkg::TIME_W-1:0]  now,
  input  logic [gic_pkg::DELAY_W-1:0] delay,
  output gic_pkg::btn_state_t         state,
  output gic_pkg::btn_state_t         state_nxt
);
  import gic_pkg::*;

  btn_state_t        state_r;
  logic [TIME_W-1:0] chg_r, chg_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BTN_RELEASED;
      chg_r   <= '0;
    end else if (ctl.acc) begin
      state_r <= state_nxt;
      chg_r   <= chg_nxt;
    end
  end

  always_comb begin
    elapsed   = now - chg_r;
    settled   = elapsed >= TIME_W'(delay);
    state_nxt = state_r;
    chg_nxt   = chg_r;
    case (state_r)
      BTN_RELEASED: begin
        if (level) begin
          state_nxt = BTN_JUST_PRESSED;
          chg_nxt   = now;
        end
      end
      BTN_JUST_PRESSED: begin
        if (settled) state_nxt = BTN_PRESSED;
        else if (!level) state_nxt = BTN_RELEASED;
      end
      BTN_PRESSED: begin
        if (!level) begin
          state_nxt = BTN_JUST_RELEASED;
          chg_nxt   = now;
        end
      end
      BTN_JUST_RELEASED: begin
        if (settled) state_nxt = BTN_RELEASED;
        else if (level) state_nxt = BTN_PRESSED;
      end
      default: state_nxt = BTN_RELEASED;
    endcase
  end

  assign state = state_r;

endmodule

### rtl/gic_merge.sv
// ---------------------------------------------------------------------------
// gic_merge
// Combines lane results: activity time, delay alignment, output registers.
// ---------------------------------------------------------------------------
module gic_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gic_pkg::pipe_ctl_t          ctl,
  input  logic [gic_pkg::AXIS_W-1:0]  filt      [gic_pkg::NUM_AXES],
  input  gic_pkg::btn_state_t         btn_state [gic_pkg::NUM_BTNS],
  input  gic_pkg::btn_state_t         btn_nxt   [gic_pkg::NUM_BTNS],
  input  logic [gic_pkg::TIME_W-1:0]  now,
  output logic [gic_pkg::AXIS_W-1:0]  filt_o    [gic_pkg::NUM_AXES],
  output gic_pkg::btn_state_t         btn_o     [gic_pkg::NUM_BTNS],
  output logic [gic_pkg::TIME_W-1:0]  act_o
);
  import gic_pkg::*;

  logic [TIME_W-1:0] act_r, act2_r;
  btn_state_t        btn2_r [NUM_BTNS];
  logic              activity;

  always_comb begin
    activity = (btn_nxt[BTN_JOY1]  == BTN_JUST_PRESSED)  ||
               (btn_nxt[BTN_JOY1]  == BTN_JUST_RELEASED) ||
               (btn_nxt[BTN_JOY2]  == BTN_JUST_PRESSED)  ||
               (btn_nxt[BTN_JOY2]  == BTN_JUST_RELEASED) ||
               (btn_nxt[BTN_LTRIG] == BTN_JUST_PRESSED)  ||
               (btn_nxt[BTN_RTRIG] == BTN_JUST_PRESSED);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= '0;
    end else if (ctl.acc && activity) begin
      act_r <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      btn2_r <= btn_state;
      act2_r <= act_r;
    end
    if (ctl.ld3) begin
      filt_o <= filt;
      btn_o  <= btn2_r;
      act_o  <= act2_r;
    end
  end

endmodule

### rtl/gamepad_input_conditioner_top.sv
// ---------------------------------------------------------------------------
// gamepad_input_conditioner_top
// Four axis lanes and four debounce lanes in parallel, merged into one item.
// ---------------------------------------------------------------------------
// Pipeline: three register stages (sum update, multiply, pick).
// Throughput: one item per cycle while out_tready is not held low; the pipeline holds up to three items.
// The per-axis reciprocal multiply sets the stage-2 path.
// Reset (rst_n low, synchronous): pipeline empty, histories unprimed, buttons
// released, times zero, deadzone 500, debounce delay 50 ms.
// ---------------------------------------------------------------------------
module gamepad_input_conditioner_top #(
  parameter int WINDOW = gic_pkg::WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // [11:0] axis1_x, [23:12] axis1_y, [35:24] axis2_x, [47:36] axis2_y,
  // [48] joy1_button, [49] joy2_button, [50] left_trigger, [51] right_trigger,
  // [83:52] now_ms, [87:84] zero
  input  logic [gic_pkg::IN_W-1:0]       in_tdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [11:0] filtered1_x, [23:12] filtered1_y, [35:24] filtered2_x,
  // [47:36] filtered2_y, [49:48] joy1_state, [51:50] joy2_state,
  // [53:52] left_state, [55:54] right_state, [87:56] last_activity_ms
  output logic [gic_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gic_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gic_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic              rdy1, rdy2, rdy3;
  logic              primed_r;
  logic [AXIS_W-1:0] deadzone_r;
  logic [DELAY_W-1:0] delay_r;
  pipe_ctl_t         ctl;

  logic [AXIS_W-1:0] sample [NUM_AXES];
  logic [AXIS_W-1:0] filt   [NUM_AXES];
  logic [AXIS_W-1:0] filt_o [NUM_AXES];
  btn_state_t        btn_state [NUM_BTNS];
  btn_state_t        btn_nxt   [NUM_BTNS];
  btn_state_t        btn_o     [NUM_BTNS];
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] act_o;

  assign rdy3       = !v3_r || out_tready;
  assign rdy2       = !v2_r || rdy3;
  assign rdy1       = !v1_r || rdy2;
  assign in_tready  = rdy1;
  assign out_tvalid = v3_r;
  assign cfg_ready  = 1'b1;

  assign ctl.acc    = in_tvalid && rdy1;
  assign ctl.ld2    = v1_r && rdy2;
  assign ctl.ld3    = v2_r && rdy3;
  assign ctl.primed = primed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      primed_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (ctl.acc) primed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= DEADZONE_RST;
      delay_r    <= DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADZONE: deadzone_r <= cfg_data[AXIS_W-1:0];
        REG_DEBOUNCE: delay_r    <= cfg_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign now = in_tdata[52 +: TIME_W];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    assign sample[a] = in_tdata[a*AXIS_W +: AXIS_W];
    gic_axis_lane #(.WINDOW(WINDOW)) u_axis (
      .clk      (clk),
      .ctl      (ctl),
      .sample   (sample[a]),
      .deadzone (deadzone_r),
      .filt     (filt[a])
    );
    assign out_tdata[a*AXIS_W +: AXIS_W] = filt_o[a];
  end

  for (genvar b = 0; b < NUM_BTNS; b++) begin : g_btn
    gic_button_lane u_btn (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .level     (in_tdata[48 + b]),
      .now       (now),
      .delay     (delay_r),
      .state     (btn_state[b]),
      .state_nxt (btn_nxt[b])
    );
    assign out_tdata[48 + 2*b +: 2] = btn_o[b];
  end

  gic_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .filt      (filt),
    .btn_state (btn_state),
    .btn_nxt   (btn_nxt),
    .now       (now),
    .filt_o    (filt_o),
    .btn_o     (btn_o),
    .act_o     (act_o)
  );

  assign out_tdata[56 +: TIME_W] = act_o;

endmodule

### rtl/gic_checker.sv
// ---------------------------------------------------------------------------
// gic_checker
// Port-level checks on the conditioner, bound to the top level.
// ---------------------------------------------------------------------------
module gic_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic [gic_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready
);
  import gic_pkg::*;

  logic              out_acc;
  logic              prev_vld_r;
  logic [1:0]        prev_j1_r;
  logic [TIME_W-1:0] prev_act_r;
  logic [1:0]        j1, j2, lt, rt;
  logic [TIME_W-1:0] act;

  assign out_acc = out_tvalid && out_tready;
  assign j1  = out_tdata[49:48];
  assign j2  = out_tdata[51:50];
  assign lt  = out_tdata[53:52];
  assign rt  = out_tdata[55:54];
  assign act = out_tdata[87:56];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_vld_r <= 1'b0;
      prev_j1_r  <= '0;
      prev_act_r <= '0;
    end else if (out_acc) begin
      prev_vld_r <= 1'b1;
      prev_j1_r  <= j1;
      prev_act_r <= act;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  a_debounce_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_vld_r && (prev_j1_r == BTN_RELEASED) |->
      (j1 == BTN_RELEASED) || (j1 == BTN_JUST_PRESSED))
    else $error("joy1 left released state without a press edge");

  a_activity: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && prev_vld_r && (act != prev_act_r) |->
      (j1 == BTN_JUST_PRESSED) || (j1 == BTN_JUST_RELEASED) ||
      (j2 == BTN_JUST_PRESSED) || (j2 == BTN_JUST_RELEASED) ||
      (lt == BTN_JUST_PRESSED) || (rt == BTN_JUST_PRESSED))
    else $error("activity time moved without a qualifying event");

endmodule

bind gamepad_input_conditioner_top gic_checker u_gic_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

### tb/tb_gamepad_input_conditioner_top.sv
// ---------------------------------------------------------------------------
// tb_gamepad_input_conditioner_top
// Self-checking bench for the gamepad input conditioner. A scoreboard class
// keeps its own copy of the axis histories, debounce lanes and registers,
// predicts every result item and compares it field by field. A short
// directed run covers priming, axis extremes, bounces, time wrap and the
// register extremes. Random phases with button hold/bounce traffic follow,
// under bursty input, a patterned output stall and one long output hold.
// ---------------------------------------------------------------------------
module tb_gamepad_input_conditioner_top;
  import gic_pkg::*;

  localparam int WINDOW_LEN  = WINDOW_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 140;

  // [47:0] axes (axis1_x lowest), [51:48] buttons, [83:52] now_ms
  typedef struct packed {
    logic [31:0]      now_ms;
    logic [3:0]       button;
    logic [3:0][11:0] axis;
  } pad_sample_t;

  // [47:0] filtered axes, [55:48] button states, [87:56] last_activity_ms
  typedef struct packed {
    logic [31:0]      activity_ms;
    logic [3:0][1:0]  state;
    logic [3:0][11:0] axis;
  } pad_result_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_LIGHT, RX_HEAVY} rx_mode_t;

  class pad_scoreboard;
    logic [11:0]     hist [4][WINDOW_LEN];
    int unsigned     ring;
    bit              primed;
    btn_state_t      btn [4];
    logic [31:0]     t_change [4];
    logic [31:0]     t_activity;
    logic [11:0]     deadzone;
    logic [15:0]     delay;
    pad_result_t     expected_pads [$];
    int              n_items, n_results, n_errors, n_writes, n_avg, n_raw;
    bit [3:0]        seen [4];
    string           axis_names [4] = '{"filtered1_x", "filtered1_y",
                                        "filtered2_x", "filtered2_y"};
    string           state_names [4] = '{"joy1_state", "joy2_state",
                                         "left_state", "right_state"};

    function new();
      ring       = 0;
      primed     = 0;
      t_activity = '0;
      deadzone   = DEADZONE_RST;
      delay      = DELAY_RST;
      for (int b = 0; b < 4; b++) begin
        btn[b]      = BTN_RELEASED;
        t_change[b] = '0;
        seen[b]     = '0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_writes++;
      if (idx == REG_DEADZONE) deadzone = data[11:0];
      else if (idx == REG_DEBOUNCE) delay = data;
    endfunction

    function int pending();
      return expected_pads.size();
    endfunction

    function pad_result_t condition_pad(pad_sample_t s);
      pad_result_t r;
      int unsigned sum, avg, diff, smp;
      logic [31:0] elapsed;
      bit          lvl;
      if (!primed) begin
        for (int a = 0; a < 4; a++)
          for (int i = 0; i < WINDOW_LEN; i++) hist[a][i] = s.axis[a];
        primed = 1;
      end
      ring = (ring + 1) % WINDOW_LEN;
      for (int a = 0; a < 4; a++) begin
        hist[a][ring] = s.axis[a];
        sum = 0;
        for (int i = 0; i < WINDOW_LEN; i++) sum += hist[a][i];
        avg  = sum / WINDOW_LEN;
        smp  = s.axis[a];
        diff = (smp >= avg) ? smp - avg : avg - smp;
        if (diff < deadzone) begin
          r.axis[a] = avg[11:0];
          n_avg++;
        end else begin
          r.axis[a] = s.axis[a];
          n_raw++;
        end
      end
      for (int b = 0; b < 4; b++) begin
        lvl     = s.button[b];
        elapsed = s.now_ms - t_change[b];
        case (btn[b])
          BTN_RELEASED: begin
            if (lvl) begin
              btn[b]      = BTN_JUST_PRESSED;
              t_change[b] = s.now_ms;
            end
          end
          BTN_JUST_PRESSED: begin
            if (elapsed >= delay) btn[b] = BTN_PRESSED;
            else if (!lvl) btn[b] = BTN_RELEASED;
          end
          BTN_PRESSED: begin
            if (!lvl) begin
              btn[b]      = BTN_JUST_RELEASED;
              t_change[b] = s.now_ms;
            end
          end
          default: begin
            if (elapsed >= delay) btn[b] = BTN_RELEASED;
            else if (lvl) btn[b] = BTN_PRESSED;
          end
        endcase
      end
      if (btn[BTN_JOY1] == BTN_JUST_PRESSED || btn[BTN_JOY1] == BTN_JUST_RELEASED ||
          btn[BTN_JOY2] == BTN_JUST_PRESSED || btn[BTN_JOY2] == BTN_JUST_RELEASED ||
          btn[BTN_LTRIG] == BTN_JUST_PRESSED || btn[BTN_RTRIG] == BTN_JUST_PRESSED)
        t_activity = s.now_ms;
      for (int b = 0; b < 4; b++) begin
        r.state[b]      = btn[b];
        seen[b][btn[b]] = 1'b1;
      end
      r.activity_ms = t_activity;
      return r;
    endfunction

    function void note_input(pad_sample_t s);
      n_items++;
      expected_pads.push_back(condition_pad(s));
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      pad_result_t got, want;
      got = data;
      n_results++;
      if (expected_pads.size() == 0) begin
        $error("result item with no expectation: %h", data);
        n_errors++;
        return;
      end
      want = expected_pads.pop_front();
      for (int a = 0; a < 4; a++)
        if (got.axis[a] !== want.axis[a]) begin
          $error("%s: expected %0d, got %0d", axis_names[a], want.axis[a], got.axis[a]);
          n_errors++;
        end
      for (int b = 0; b < 4; b++)
        if (got.state[b] !== want.state[b]) begin
          $error("%s: expected %0d, got %0d", state_names[b], want.state[b], got.state[b]);
          n_errors++;
        end
      if (got.activity_ms !== want.activity_ms) begin
        $error("last_activity_ms: expected %0d, got %0d", want.activity_ms, got.activity_ms);
        n_errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_W-1:0]       in_tdata  = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  pad_scoreboard sb;
  logic [31:0]   clock_ms;
  logic [11:0]   center [4];
  bit            hold_level [4];
  int            burst_left = 0;
  int            hold_seq   = 0;
  int            hold_seen  = 0;
  int            hold_cnt   = 0;
  int            rx_left    = 0;
  rx_mode_t      rx_mode    = RX_OPEN;
  int            cycles     = 0;

  gamepad_input_conditioner_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // output stall pattern, with a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen  <= hold_seq;
      hold_cnt   <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= (hold_cnt == 1);
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(20, 120);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_tready <= 1'b1;
        RX_HALF:  out_tready <= 1'($urandom_range(0, 1));
        RX_LIGHT: out_tready <= ($urandom_range(0, 7) != 0);
        default:  out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
  end

  task automatic send_pad(input logic [11:0] x1, input logic [11:0] y1,
                          input logic [11:0] x2, input logic [11:0] y2,
                          input logic [3:0] btns, input logic [31:0] stamp);
    pad_sample_t s;
    s.axis[0] = x1;
    s.axis[1] = y1;
    s.axis[2] = x2;
    s.axis[3] = y2;
    s.button  = btns;
    s.now_ms  = stamp;
    in_tdata  <= {4'b0000, s};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(s);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] dz, input logic [CFG_DATA_W-1:0] dly);
    cfg_index <= REG_DEADZONE;
    cfg_data  <= dz;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(REG_DEADZONE, dz);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= dly;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(REG_DEBOUNCE, dly);
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  task automatic send_random_pad(input bit no_gap);
    logic [11:0] v [4];
    logic [3:0]  lv;
    int          r, span, x;
    int unsigned dly;
    dly = sb.delay;
    if (!no_gap && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    r = $urandom_range(0, 99);
    if (r < 2) clock_ms = $urandom();
    else if (r < 50) clock_ms += $urandom_range(0, dly / 4 + 1);
    else if (r < 85) clock_ms += $urandom_range(dly / 2, dly + dly / 2 + 2);
    else clock_ms += $urandom_range(0, 3);
    span = sb.deadzone / 2 + 2;
    for (int a = 0; a < 4; a++) begin
      r = $urandom_range(0, 99);
      if (r < 10) center[a] = 12'($urandom_range(0, 4095));
      if (r < 65) begin
        x = int'(center[a]) + $urandom_range(0, 2 * span) - span;
        v[a] = (x < 0) ? 12'd0 : (x > 4095) ? 12'd4095 : x[11:0];
      end else if (r < 90) begin
        v[a] = 12'($urandom_range(0, 4095));
      end else begin
        v[a] = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
      end
    end
    for (int b = 0; b < 4; b++) begin
      if ($urandom_range(0, 9) == 0) hold_level[b] = ~hold_level[b];
      lv[b] = hold_level[b] ^ ($urandom_range(0, 11) == 0);
    end
    send_pad(v[0], v[1], v[2], v[3], lv, clock_ms);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] dz, dly;
    sb = new();
    for (int a = 0; a < 4; a++) begin
      center[a]     = 12'd2048;
      hold_level[a] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: priming, extremes, bounces and a time wrap
    send_pad(12'd0, 12'd4095, 12'd2048, 12'd1, 4'b0000, 32'hFFFF_FFF0);
    send_pad(12'd4095, 12'd0, 12'd2060, 12'd2, 4'b1111, 32'hFFFF_FFF5);
    send_pad(12'd300, 12'd3900, 12'd2050, 12'd600, 4'b0000, 32'hFFFF_FFFF);
    send_pad(12'd250, 12'd3800, 12'd2040, 12'd300, 4'b1010, 32'hFFFF_FFFE);
    send_pad(12'd280, 12'd3850, 12'd2045, 12'd250, 4'b1111, 32'h0000_003A);
    send_pad(12'd290, 12'd3860, 12'd2047, 12'd260, 4'b0000, 32'h0000_003B);
    send_pad(12'd295, 12'd3870, 12'd2049, 12'd265, 4'b1111, 32'h0000_003C);
    send_pad(12'd300, 12'd3880, 12'd2051, 12'd270, 4'b0101, 32'h0000_003D);
    send_pad(12'd305, 12'd3890, 12'd2052, 12'd275, 4'b0101, 32'h0000_006F);
    send_pad(12'd310, 12'd3895, 12'd2053, 12'd280, 4'b0000, 32'h0000_0070);
    send_pad(12'd315, 12'd3899, 12'd2054, 12'd285, 4'b0000, 32'h0000_00A1);
    send_pad(12'd320, 12'd3900, 12'd2055, 12'd290, 4'b0000, 32'h0000_00A2);
    drain();
    // zero deadzone (upper data bits set), zero delay
    write_regs(16'hF000, 16'h0000);
    send_pad(12'd320, 12'd3900, 12'd2055, 12'd290, 4'b1111, 32'h0000_1000);
    send_pad(12'd321, 12'd3901, 12'd2056, 12'd291, 4'b1111, 32'h0000_1000);
    send_pad(12'd322, 12'd3902, 12'd2057, 12'd292, 4'b0000, 32'h0000_1001);
    send_pad(12'd323, 12'd3903, 12'd2058, 12'd293, 4'b0000, 32'h0000_1001);
    drain();
    // widest deadzone, longest delay
    write_regs(16'h0FFF, 16'hFFFF);
    send_pad(12'd0, 12'd0, 12'd0, 12'd0, 4'b1111, 32'hABCD_0000);
    send_pad(12'd0, 12'd0, 12'd0, 12'd0, 4'b1111, 32'hABCD_FFFE);
    send_pad(12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'b1111, 32'hABCD_FFFF);
    send_pad(12'd4095, 12'd4095, 12'd4095, 12'd4095, 4'b0000, 32'hABCE_0000);
    drain();

    clock_ms = 32'hFFFF_0000;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin dz = 16'd500;  dly = 16'd50;    end
        1:       begin dz = 16'h0000; dly = 16'h0000;  end
        2:       begin dz = 16'hFFFF; dly = 16'hFFFF;  end
        3:       begin dz = 16'($urandom()); dly = 16'($urandom_range(0, 200)); end
        4:       begin dz = 16'($urandom()); dly = 16'($urandom()); end
        default: begin dz = 16'd120;  dly = 16'd10;    end
      endcase
      write_regs(dz, dly);
      if (p == 0) begin
        // long output hold-off while input keeps coming
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 30; i++) send_random_pad(1'b1);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_pad(1'b0);
        if (p == PHASES - 1 && i == PHASE_ITEMS / 2) drain();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("run covered %0d items and %0d result items across %0d register writes",
             sb.n_items, sb.n_results, sb.n_writes);
    $display("axis outputs averaged %0d, raw %0d; button states seen %b %b %b %b",
             sb.n_avg, sb.n_raw, sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3]);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
